FILE: hw/rtl/lupp_pkg.sv
// ----------------------------------------------------------------------------
// lupp_pkg: shared types, codes and helpers of the LU decomposition block
// Sequencer states, register indexes and fixed-point helper functions.
// ----------------------------------------------------------------------------
package lupp_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_THRESH = 1'b1;

  // Sequencer states
  typedef enum logic [4:0] {
    S_LOAD,
    S_PIV_RD,
    S_PIV_CMP,
    S_PIV_CHK,
    S_SW_RA,
    S_SW_RB,
    S_SW_WA,
    S_SW_WB,
    S_EL_PRD,
    S_EL_PGET,
    S_EL_ARD,
    S_EL_DIV,
    S_EL_DWAIT,
    S_EL_URD,
    S_EL_MRD,
    S_EL_MUL,
    S_EL_SUB,
    S_DET_RD,
    S_DET_MUL,
    S_DET_ACC,
    S_DET_NEG,
    S_EM_RD,
    S_EM_OUT,
    S_SING
  } state_e;

  // Magnitude of a signed 32-bit value as an unsigned 32-bit value
  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    logic [31:0] r;
    r = x[31] ? 32'(-x) : 32'(x);
    return r;
  endfunction

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v[65:31] == {35{v[65]}}) begin
      r = v[31:0];
    end else if (v[65]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/lupp_divider.sv
// ----------------------------------------------------------------------------
// lupp_divider: unsigned restoring divider
// Produces one quotient bit per cycle; done_o pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module lupp_divider #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [32+FRAC_BITS-1:0] dividend_i,
  input  logic [31:0]             divisor_i,
  output logic                    done_o,
  output logic [32+FRAC_BITS-1:0] quotient_o
);

  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [32:0]   rem_q;
  logic [NW-1:0] quo_q;
  logic [31:0]   dvs_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic          done_q;
  logic [32:0]   rem_sh;
  logic [33:0]   diff;

  // Trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem_q[31:0], quo_q[NW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  end

  // Control: run counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(NW);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: shift in one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      if (!diff[33]) begin
        rem_q <= diff[32:0];
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q)) else $error("divider done without a run");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q) else $error("divider done while running");
  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> cnt_q != '0) else $error("divider running with empty count");

endmodule

FILE: hw/rtl/lu_decomposition_partial_pivot.sv
// ----------------------------------------------------------------------------
// lu_decomposition_partial_pivot: fixed-point LU factorization with pivoting
// Loads a square matrix and emits its L and U entries and the determinant.
// ----------------------------------------------------------------------------
// Usage:
//  - Configure matrix_size (index 0) and pivot_threshold (index 1) through
//    cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
//  - Present one element per request: a request is taken on a clock edge
//    with start_i high and busy_o low. Elements go in row-major order, one
//    per cycle at most.
//  - After the last element busy_o rises; the sequencer factors the matrix
//    with one shared multiplier and one bit-serial divider over two memories.
//  - Results come out for one cycle each, marked by valid_o: n*n entries
//    (row, col, L, U, pivot source), the last one with last_o and the
//    determinant. A singular matrix gives one result with singular_o and
//    last_o. The receiver cannot stall the results.
//  - Run time after the last element is set by the divider (one bit per
//    cycle) and the single memory read port.
//  - Reset returns the sequencer to loading with an empty count and restores
//    size 8 and threshold 1; the matrix memories hold no reset value.
// ----------------------------------------------------------------------------
module lu_decomposition_partial_pivot #(
  parameter int unsigned MAX_SIZE  = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lupp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [30:0]                    cfg_data_i,
  input  logic                           start_i,
  input  logic signed [31:0]             element_i,
  output logic                           busy_o,
  output logic                           valid_o,
  output logic [2:0]                     row_o,
  output logic [2:0]                     col_o,
  output logic signed [31:0]             lower_value_o,
  output logic signed [31:0]             upper_value_o,
  output logic [2:0]                     pivot_source_o,
  output logic                           singular_o,
  output logic signed [31:0]             determinant_o,
  output logic                           last_o
);

  localparam int unsigned IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned CELLS = MAX_SIZE * MAX_SIZE;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned NW    = 32 + FRAC_BITS;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  lupp_pkg::state_e state_q, state_d;

  logic [3:0]  size_q;
  logic [30:0] thr_q;
  logic [IW-1:0] nm1;
  logic [IW-1:0] i_q, j_q, k_q, bi_q;
  logic [31:0] best_q;
  logic signed [31:0] piv_q, f_q, tmp_q, ltmp_q, aij_q, det_q;
  logic        qneg_q, pneg_q, parity_q;
  logic [63:0] prod_q;
  logic [2:0]  ord_q [MAX_SIZE];
  logic        valid_o_q;

  // Memories
  logic signed [31:0] work_mem  [CELLS];
  logic signed [31:0] lower_mem [CELLS];
  logic signed [31:0] wrd_q, lrd_q;
  logic [AW-1:0] raddr, waddr, lwaddr;
  logic signed [31:0] wdata, lwdata;
  logic          we, lwe;

  // Shared units
  logic          div_start, div_done;
  logic [NW-1:0] div_quo;
  logic [31:0]   mul_a, mul_b;
  logic signed [31:0] fq;
  logic [63:0]   prod_sh;
  logic signed [65:0] sprod;
  logic          accept;
  logic          swap;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                              input logic [IW-1:0] c);
    return AW'(int'(r) * MAX_SIZE + int'(c));
  endfunction

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != lupp_pkg::S_LOAD);
  assign swap   = (bi_q != k_q);

  // Effective size minus one
  always_comb begin
    if (size_q == 4'd0) begin
      nm1 = '0;
    end else if (int'(size_q) > MAX_SIZE) begin
      nm1 = IW'(MAX_SIZE - 1);
    end else begin
      nm1 = IW'(size_q - 4'd1);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 4'd8;
      thr_q  <= 31'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lupp_pkg::CFG_MATRIX_SIZE:  size_q <= cfg_data_i[3:0];
        lupp_pkg::CFG_PIVOT_THRESH: thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Signed product and saturated quotient
  always_comb begin
    mul_a   = (state_q == lupp_pkg::S_DET_MUL) ? lupp_pkg::mag32(det_q) : lupp_pkg::mag32(f_q);
    mul_b   = (state_q == lupp_pkg::S_DET_MUL) ? lupp_pkg::mag32(wrd_q) : lupp_pkg::mag32(tmp_q);
    prod_sh = prod_q >> FRAC_BITS;
    sprod   = pneg_q ? -$signed({2'b00, prod_sh}) : $signed({2'b00, prod_sh});
    fq      = lupp_pkg::sat66(qneg_q ? -$signed(66'(div_quo)) : $signed(66'(div_quo)));
  end

  // Next state and memory control
  always_comb begin
    state_d   = state_q;
    raddr     = '0;
    waddr     = '0;
    wdata     = '0;
    we        = 1'b0;
    lwaddr    = '0;
    lwdata    = '0;
    lwe       = 1'b0;
    div_start = 1'b0;
    case (state_q)
      lupp_pkg::S_LOAD: begin
        if (accept) begin
          we    = 1'b1;
          waddr = cell_addr(i_q, j_q);
          wdata = element_i;
          if (i_q == nm1 && j_q == nm1) begin
            state_d = lupp_pkg::S_PIV_RD;
          end
        end
      end
      lupp_pkg::S_PIV_RD: begin
        raddr   = cell_addr(i_q, k_q);
        state_d = lupp_pkg::S_PIV_CMP;
      end
      lupp_pkg::S_PIV_CMP: begin
        state_d = (i_q == nm1) ? lupp_pkg::S_PIV_CHK : lupp_pkg::S_PIV_RD;
      end
      lupp_pkg::S_PIV_CHK: begin
        if (best_q < {1'b0, thr_q} || best_q == '0) begin
          state_d = lupp_pkg::S_SING;
        end else if (swap) begin
          state_d = lupp_pkg::S_SW_RA;
        end else begin
          state_d = lupp_pkg::S_EL_PRD;
        end
      end
      lupp_pkg::S_SW_RA: begin
        raddr   = cell_addr(k_q, j_q);
        state_d = lupp_pkg::S_SW_RB;
      end
      lupp_pkg::S_SW_RB: begin
        raddr   = cell_addr(bi_q, j_q);
        state_d = lupp_pkg::S_SW_WA;
      end
      lupp_pkg::S_SW_WA: begin
        we      = 1'b1;
        waddr   = cell_addr(k_q, j_q);
        wdata   = wrd_q;
        lwe     = (j_q < k_q);
        lwaddr  = cell_addr(k_q, j_q);
        lwdata  = lrd_q;
        state_d = lupp_pkg::S_SW_WB;
      end
      lupp_pkg::S_SW_WB: begin
        we      = 1'b1;
        waddr   = cell_addr(bi_q, j_q);
        wdata   = tmp_q;
        lwe     = (j_q < k_q);
        lwaddr  = cell_addr(bi_q, j_q);
        lwdata  = ltmp_q;
        state_d = (j_q == nm1) ? lupp_pkg::S_EL_PRD : lupp_pkg::S_SW_RA;
      end
      lupp_pkg::S_EL_PRD: begin
        raddr   = cell_addr(k_q, k_q);
        state_d = lupp_pkg::S_EL_PGET;
      end
      lupp_pkg::S_EL_PGET: begin
        state_d = (k_q == nm1) ? lupp_pkg::S_DET_RD : lupp_pkg::S_EL_ARD;
      end
      lupp_pkg::S_EL_ARD: begin
        raddr   = cell_addr(i_q, k_q);
        state_d = lupp_pkg::S_EL_DIV;
      end
      lupp_pkg::S_EL_DIV: begin
        div_start = 1'b1;
        state_d   = lupp_pkg::S_EL_DWAIT;
      end
      lupp_pkg::S_EL_DWAIT: begin
        if (div_done) begin
          lwe     = 1'b1;
          lwaddr  = cell_addr(i_q, k_q);
          lwdata  = fq;
          we      = 1'b1;
          waddr   = cell_addr(i_q, k_q);
          wdata   = '0;
          state_d = lupp_pkg::S_EL_URD;
        end
      end
      lupp_pkg::S_EL_URD: begin
        raddr   = cell_addr(k_q, j_q);
        state_d = lupp_pkg::S_EL_MRD;
      end
      lupp_pkg::S_EL_MRD: begin
        raddr   = cell_addr(i_q, j_q);
        state_d = lupp_pkg::S_EL_MUL;
      end
      lupp_pkg::S_EL_MUL: begin
        state_d = lupp_pkg::S_EL_SUB;
      end
      lupp_pkg::S_EL_SUB: begin
        we    = 1'b1;
        waddr = cell_addr(i_q, j_q);
        wdata = lupp_pkg::sat66($signed({{34{aij_q[31]}}, aij_q}) - sprod);
        if (j_q != nm1) begin
          state_d = lupp_pkg::S_EL_URD;
        end else if (i_q != nm1) begin
          state_d = lupp_pkg::S_EL_ARD;
        end else begin
          state_d = lupp_pkg::S_PIV_RD;
        end
      end
      lupp_pkg::S_DET_RD: begin
        raddr   = cell_addr(i_q, i_q);
        state_d = lupp_pkg::S_DET_MUL;
      end
      lupp_pkg::S_DET_MUL: begin
        state_d = lupp_pkg::S_DET_ACC;
      end
      lupp_pkg::S_DET_ACC: begin
        state_d = (i_q == nm1) ? lupp_pkg::S_DET_NEG : lupp_pkg::S_DET_RD;
      end
      lupp_pkg::S_DET_NEG: begin
        state_d = lupp_pkg::S_EM_RD;
      end
      lupp_pkg::S_EM_RD: begin
        raddr   = cell_addr(i_q, j_q);
        state_d = lupp_pkg::S_EM_OUT;
      end
      lupp_pkg::S_EM_OUT: begin
        state_d = (i_q == nm1 && j_q == nm1) ? lupp_pkg::S_LOAD : lupp_pkg::S_EM_RD;
      end
      lupp_pkg::S_SING: begin
        state_d = lupp_pkg::S_LOAD;
      end
      default: begin
        state_d = lupp_pkg::S_LOAD;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lupp_pkg::S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Matrix memories with registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      work_mem[waddr] <= wdata;
    end
    wrd_q <= work_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (lwe) begin
      lower_mem[lwaddr] <= lwdata;
    end
    lrd_q <= lower_mem[raddr];
  end

  // Loop counters, row order and output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      bi_q      <= '0;
      best_q    <= '0;
      parity_q  <= 1'b0;
      valid_o_q <= 1'b0;
      for (int unsigned x = 0; x < MAX_SIZE; x++) begin
        ord_q[x] <= 3'(x);
      end
    end else begin
      valid_o_q <= 1'b0;
      case (state_q)
        lupp_pkg::S_LOAD: begin
          if (accept) begin
            if (j_q == nm1) begin
              j_q <= '0;
              i_q <= (i_q == nm1) ? '0 : i_q + 1'b1;
            end else begin
              j_q <= j_q + 1'b1;
            end
            if (i_q == nm1 && j_q == nm1) begin
              k_q      <= '0;
              bi_q     <= '0;
              best_q   <= '0;
              parity_q <= 1'b0;
              for (int unsigned x = 0; x < MAX_SIZE; x++) begin
                ord_q[x] <= 3'(x);
              end
            end
          end
        end
        lupp_pkg::S_PIV_CMP: begin
          if (lupp_pkg::mag32(wrd_q) > best_q) begin
            best_q <= lupp_pkg::mag32(wrd_q);
            bi_q   <= i_q;
          end
          if (i_q != nm1) begin
            i_q <= i_q + 1'b1;
          end
        end
        lupp_pkg::S_PIV_CHK: begin
          j_q <= '0;
          if (swap) begin
            ord_q[k_q]  <= ord_q[bi_q];
            ord_q[bi_q] <= ord_q[k_q];
            parity_q    <= ~parity_q;
          end
        end
        lupp_pkg::S_SW_WB: begin
          if (j_q != nm1) begin
            j_q <= j_q + 1'b1;
          end
        end
        lupp_pkg::S_EL_PGET: begin
          i_q <= (k_q == nm1) ? '0 : k_q + 1'b1;
        end
        lupp_pkg::S_EL_DWAIT: begin
          j_q <= k_q + 1'b1;
        end
        lupp_pkg::S_EL_SUB: begin
          if (j_q != nm1) begin
            j_q <= j_q + 1'b1;
          end else if (i_q != nm1) begin
            i_q <= i_q + 1'b1;
          end else begin
            k_q    <= k_q + 1'b1;
            i_q    <= k_q + 1'b1;
            bi_q   <= k_q + 1'b1;
            best_q <= '0;
          end
        end
        lupp_pkg::S_DET_ACC: begin
          if (i_q != nm1) begin
            i_q <= i_q + 1'b1;
          end
        end
        lupp_pkg::S_DET_NEG: begin
          i_q <= '0;
          j_q <= '0;
        end
        lupp_pkg::S_EM_OUT: begin
          valid_o_q <= 1'b1;
          if (j_q == nm1) begin
            j_q <= '0;
            i_q <= (i_q == nm1) ? '0 : i_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        lupp_pkg::S_SING: begin
          valid_o_q <= 1'b1;
          i_q       <= '0;
          j_q       <= '0;
        end
        default: ;
      endcase
    end
  end

  // Arithmetic datapath and result fields
  always_ff @(posedge clk_i) begin
    case (state_q)
      lupp_pkg::S_LOAD: begin
        det_q <= ONE;
      end
      lupp_pkg::S_SW_RB: begin
        tmp_q  <= wrd_q;
        ltmp_q <= lrd_q;
      end
      lupp_pkg::S_EL_PGET: begin
        piv_q <= wrd_q;
      end
      lupp_pkg::S_EL_DIV: begin
        qneg_q <= wrd_q[31] ^ piv_q[31];
      end
      lupp_pkg::S_EL_DWAIT: begin
        if (div_done) begin
          f_q <= fq;
        end
      end
      lupp_pkg::S_EL_MRD: begin
        tmp_q <= wrd_q;
      end
      lupp_pkg::S_EL_MUL: begin
        prod_q <= mul_a * mul_b;
        pneg_q <= f_q[31] ^ tmp_q[31];
        aij_q  <= wrd_q;
      end
      lupp_pkg::S_DET_MUL: begin
        prod_q <= mul_a * mul_b;
        pneg_q <= det_q[31] ^ wrd_q[31];
      end
      lupp_pkg::S_DET_ACC: begin
        det_q <= lupp_pkg::sat66(sprod);
      end
      lupp_pkg::S_DET_NEG: begin
        if (parity_q) begin
          det_q <= lupp_pkg::sat66(-$signed({{34{det_q[31]}}, det_q}));
        end
      end
      lupp_pkg::S_EM_OUT: begin
        row_o          <= 3'(i_q);
        col_o          <= 3'(j_q);
        lower_value_o  <= (i_q > j_q) ? lrd_q : ((i_q == j_q) ? ONE : 32'sd0);
        upper_value_o  <= (i_q <= j_q) ? wrd_q : 32'sd0;
        pivot_source_o <= ord_q[i_q];
        singular_o     <= 1'b0;
        last_o         <= (i_q == nm1 && j_q == nm1);
        determinant_o  <= (i_q == nm1 && j_q == nm1) ? det_q : 32'sd0;
      end
      lupp_pkg::S_SING: begin
        row_o          <= '0;
        col_o          <= '0;
        lower_value_o  <= '0;
        upper_value_o  <= '0;
        pivot_source_o <= '0;
        singular_o     <= 1'b1;
        last_o         <= 1'b1;
        determinant_o  <= '0;
      end
      default: ;
    endcase
  end

  assign valid_o = valid_o_q;

  lupp_divider #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({lupp_pkg::mag32(wrd_q), {FRAC_BITS{1'b0}}}),
    .divisor_i (lupp_pkg::mag32(piv_q)),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o)) else $error("result outside a run");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == lupp_pkg::S_EL_DWAIT) else $error("divider done out of turn");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy_o) else $error("last result before run end");
  a_pivot_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lupp_pkg::S_EL_DIV |-> piv_q != '0) else $error("division by zero pivot");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the fixed-point LU decomposition block
// Loads square matrices one element per request and predicts every L/U
// entry, pivot source and determinant in a scoreboard, then compares each
// strobed result with all its fields at once in arrival order.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAXN = 8;
  localparam int unsigned FRAC = 16;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    logic [2:0]         src;
    logic               singular;
    logic signed [31:0] det;
    logic               last;
  } lu_entry_t;

  // Scoreboard: shadow factorization state and the queue of predicted entries
  class lu_scoreboard;
    int unsigned size_reg = 8;
    int unsigned thresh = 1;
    logic signed [31:0] work[64];
    logic signed [31:0] lower[64];
    int unsigned order[8];
    int unsigned load_cnt;
    bit parity;
    logic signed [31:0] det;
    lu_entry_t pending[$];
    int unsigned errors;

    function void restart();
      for (int i = 0; i < MAXN; i++) order[i] = i;
      parity = 0;
      det = Q_ONE;
      load_cnt = 0;
    endfunction

    function int unsigned eff_size();
      if (size_reg == 0) return 1;
      if (size_reg > MAXN) return MAXN;
      return size_reg;
    endfunction

    function logic signed [31:0] sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function logic [63:0] mag(logic signed [31:0] x);
      longint w;
      w = x;
      return (w < 0) ? 64'(-w) : 64'(w);
    endfunction

    function longint qmul(logic signed [31:0] a, logic signed [31:0] b);
      logic [63:0] p;
      p = (mag(a) * mag(b)) >> FRAC;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function logic signed [31:0] qdiv(logic signed [31:0] a, logic signed [31:0] b);
      logic [63:0] q;
      q = (mag(a) << FRAC) / mag(b);
      return sat(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q));
    endfunction

    // Factor in place; return 0 when a pivot is too small
    function bit factor(int unsigned n);
      logic [63:0] best, m;
      int unsigned bi, t;
      logic signed [31:0] tmp, f;
      for (int i = 0; i < 64; i++) lower[i] = 0;
      for (int k = 0; k < n; k++) begin
        best = 0;
        bi = k;
        for (int i = k; i < n; i++) begin
          m = mag(work[i*MAXN+k]);
          if (m > best) begin
            best = m;
            bi = i;
          end
        end
        if (best < thresh || best == 0) return 0;
        if (bi != k) begin
          for (int j = 0; j < n; j++) begin
            tmp = work[k*MAXN+j];
            work[k*MAXN+j] = work[bi*MAXN+j];
            work[bi*MAXN+j] = tmp;
          end
          for (int j = 0; j < k; j++) begin
            tmp = lower[k*MAXN+j];
            lower[k*MAXN+j] = lower[bi*MAXN+j];
            lower[bi*MAXN+j] = tmp;
          end
          t = order[k];
          order[k] = order[bi];
          order[bi] = t;
          parity ^= 1'b1;
        end
        for (int i = k + 1; i < n; i++) begin
          f = qdiv(work[i*MAXN+k], work[k*MAXN+k]);
          lower[i*MAXN+k] = f;
          work[i*MAXN+k] = 0;
          for (int j = k + 1; j < n; j++)
            work[i*MAXN+j] = sat(longint'(work[i*MAXN+j]) - qmul(f, work[k*MAXN+j]));
        end
      end
      for (int i = 0; i < n; i++) det = sat(qmul(det, work[i*MAXN+i]));
      if (parity) det = sat(-longint'(det));
      return 1;
    endfunction

    // Note one accepted request; predict the entries a completed matrix causes
    function void note_element(logic signed [31:0] elem);
      int unsigned n, total;
      lu_entry_t e;
      n = eff_size();
      total = n * n;
      if (load_cnt < total) work[(load_cnt / n)*MAXN + load_cnt % n] = elem;
      load_cnt++;
      if (load_cnt < total) return;
      restart();
      if (!factor(n)) begin
        e = '0;
        e.singular = 1;
        e.last = 1;
        pending.push_back(e);
        restart();
        return;
      end
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          e.row = 3'(i);
          e.col = 3'(j);
          e.lower = (i > j) ? lower[i*MAXN+j] : ((i == j) ? Q_ONE : 32'sd0);
          e.upper = (i <= j) ? work[i*MAXN+j] : 32'sd0;
          e.src = 3'(order[i]);
          e.singular = 0;
          e.last = (i == n - 1) && (j == n - 1);
          e.det = e.last ? det : 32'sd0;
          pending.push_back(e);
        end
      end
      load_cnt = 0;
    endfunction

    function void check_result(lu_entry_t got);
      lu_entry_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [lupp_pkg::CFG_IDX_W-1:0] cfg_idx_i = lupp_pkg::CFG_MATRIX_SIZE;
  logic [30:0] cfg_data_i = '0;
  logic start_i = 0;
  logic signed [31:0] element_i = '0;
  logic busy_o, valid_o, singular_o, last_o;
  logic [2:0] row_o, col_o, pivot_source_o;
  logic signed [31:0] lower_value_o, upper_value_o, determinant_o;

  lu_scoreboard lu_sb = new();
  int unsigned idle_pct = 0;
  int unsigned sent = 0;
  longint cycles = 0;

  lu_decomposition_partial_pivot uut (.*);

  always #10 clk_i = ~clk_i;

  // Check every strobed result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      lu_sb.check_result({row_o, col_o, lower_value_o, upper_value_o, pivot_source_o,
                          singular_o, determinant_o, last_o});
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Hold start until taken, then idle at random
  task automatic send_element(logic signed [31:0] v);
    int unsigned gap;
    start_i <= 1'b1;
    element_i <= v;
    do @(posedge clk_i); while (busy_o);
    lu_sb.note_element(v);
    sent++;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every predicted entry has arrived
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (lu_sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_config(int unsigned sz, int unsigned thr);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= lupp_pkg::CFG_MATRIX_SIZE;
    cfg_data_i <= 31'(sz);
    @(posedge clk_i);
    cfg_idx_i <= lupp_pkg::CFG_PIVOT_THRESH;
    cfg_data_i <= 31'(thr);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lu_sb.size_reg = sz & 15;
    lu_sb.thresh = thr & 32'h7fff_ffff;
  endtask

  function automatic logic signed [31:0] rand_element();
    case ($urandom_range(0, 11))
      0:       return 32'sd0;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh8000_0000;
      3, 4:    return $urandom;
      default: return $signed($urandom_range(0, 8 << FRAC)) - (32'sd4 << FRAC);
    endcase
  endfunction

  initial begin
    int unsigned sz, n, thr;
    int unsigned mat;
    lu_sb.restart();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single element at full scale and a zero pivot
    write_config(1, 1);
    send_element(32'sh7fff_ffff);
    write_config(0, 0);
    send_element(32'sd0);
    send_element(32'sh8000_0000);
    // Row swap needed, then a pivot tie that keeps the current row
    write_config(2, 1);
    send_element(Q_ONE);
    send_element(2 * Q_ONE);
    send_element(3 * Q_ONE);
    send_element(4 * Q_ONE);
    send_element(-2 * Q_ONE);
    send_element(Q_ONE);
    send_element(2 * Q_ONE);
    send_element(3 * Q_ONE);
    // Pivot below a large threshold
    write_config(2, 32'h7fff_ffff);
    send_element(32'sh7fff_fffe);
    send_element(Q_ONE);
    send_element(Q_ONE);
    send_element(Q_ONE);
    // Saturating quotients, updates and determinant
    write_config(3, 0);
    send_element(1);
    send_element(32'sh7fff_ffff);
    send_element(32'sh8000_0000);
    send_element(32'sh8000_0000);
    send_element(32'sh7fff_ffff);
    send_element(1);
    send_element(32'sh7fff_ffff);
    send_element(32'sh8000_0000);
    send_element(-1);

    // Random matrices over several idling phases
    mat = 0;
    while (sent < 125) begin
      case ((mat / 4) % 4)
        0:       idle_pct = 0;
        1:       idle_pct = 84;
        2:       idle_pct = 7;
        default: idle_pct = 30;
      endcase
      if (mat == 0 || $urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 19))
          0:       sz = 8;
          1:       sz = $urandom_range(9, 15);
          2:       sz = 0;
          default: sz = $urandom_range(1, 5);
        endcase
        case ($urandom_range(0, 9))
          0:       thr = 0;
          1:       thr = $urandom_range(0, 32'h7fff_ffff);
          2:       thr = $urandom_range(Q_ONE, 8 * Q_ONE);
          default: thr = $urandom_range(1, 256);
        endcase
        write_config(sz, thr);
      end
      n = lu_sb.eff_size();
      repeat (n * n) send_element(rand_element());
      mat++;
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (lu_sb.errors == 0 && lu_sb.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
